FILE: hdl/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg: quaternion to euler 360 package
// Widths, turn constants, CORDIC arctangent table and output scaling helpers.
// ----------------------------------------------------------------------------
package qte_pkg;

	localparam int QW        = 16;  // quaternion component
	localparam int AW        = 16;  // output angle
	localparam int PW        = 32;  // component product, Q4.28
	localparam int MW        = 34;  // rotation matrix term
	localparam int GW        = 30;  // clamped asin argument
	localparam int RW        = 57;  // sqrt radicand
	localparam int SQ_STEPS  = 29;  // one result bit per step
	localparam int CW        = 38;  // CORDIC x/y
	localparam int ACC_W     = 35;  // binary angle, full turn = 2^32
	localparam int TW        = 33;  // angle in 0..full turn
	localparam int SW        = 24;  // unit scale factor
	localparam int XW        = 36;  // angle unfold arithmetic
	localparam int NORM_STEPS = 5;  // shifts 16,8,4,2,1
	localparam int MAX_STAGES = 24;
	localparam int CORDIC_STAGES_DEF = 16;

	localparam logic signed [ACC_W-1:0] HALF_TURN    = 35'sd2147483648;
	localparam logic signed [ACC_W-1:0] QUARTER_TURN = 35'sd1073741824;
	localparam logic signed [XW-1:0]    FULL_TURN_X  = 36'sd4294967296;
	localparam logic signed [XW-1:0]    HALF_TURN_X  = 36'sd2147483648;
	localparam logic [TW-1:0]           FULL_TURN    = 33'h1_0000_0000;
	localparam logic signed [MW-1:0]    ONE_Q28      = 34'sd268435456;
	localparam logic [RW-1:0]           ONE_SQ       = 57'h100_0000_0000_0000;
	localparam logic [SW-1:0]           DEG_SCALE    = 24'd46080;
	localparam logic [SW-1:0]           RAD_SCALE    = 24'd13176795;
	localparam logic [AW-1:0]           DEG_MAX      = 16'd46080;
	localparam logic [AW-1:0]           RAD_MAX      = 16'd51472;

	typedef enum logic {
		UNIT_DEG = 1'b0,
		UNIT_RAD = 1'b1
	} unit_t;

	typedef struct packed {
		logic signed [GW-1:0] g;
		logic signed [MW-1:0] m11;
		logic signed [MW-1:0] m12;
		logic signed [MW-1:0] m31;
		logic signed [MW-1:0] gz;
		logic                 gx_neg;
	} geo_t;

	function automatic int cordic_lat(input int n);
		return 2 + NORM_STEPS + n;
	endfunction

	function automatic logic [29:0] atan_at(input int i);
		logic [29:0] r;
		case (i)
			0:       r = 30'h20000000;
			1:       r = 30'h12E4051E;
			2:       r = 30'h09FB385B;
			3:       r = 30'h051111D4;
			4:       r = 30'h028B0D43;
			5:       r = 30'h0145D7E1;
			6:       r = 30'h00A2F61E;
			7:       r = 30'h00517C55;
			8:       r = 30'h0028BE53;
			9:       r = 30'h00145F2F;
			10:      r = 30'h000A2F98;
			11:      r = 30'h000517CC;
			12:      r = 30'h00028BE6;
			13:      r = 30'h000145F3;
			14:      r = 30'h0000A2FA;
			15:      r = 30'h0000517D;
			16:      r = 30'h000028BE;
			17:      r = 30'h0000145F;
			18:      r = 30'h00000A30;
			19:      r = 30'h00000518;
			20:      r = 30'h0000028C;
			21:      r = 30'h00000146;
			22:      r = 30'h000000A3;
			23:      r = 30'h00000051;
			default: r = 30'h0;
		endcase
		return r;
	endfunction

	function automatic logic [TW-1:0] to_turn(input logic signed [XW-1:0] v);
		logic [TW-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > FULL_TURN_X) begin
			r = FULL_TURN;
		end else begin
			r = v[TW-1:0];
		end
		return r;
	endfunction

	function automatic logic [AW-1:0] round_unit(input logic [TW+SW-1:0] p, input unit_t u);
		logic [TW+SW:0] s;
		logic [AW-1:0]  r;
		if (u == UNIT_RAD) begin
			s = {1'b0, p} + (58'd1 << 39);
			r = s[40 +: AW];
		end else begin
			s = {1'b0, p} + (58'd1 << 31);
			r = s[32 +: AW];
		end
		return r;
	endfunction

endpackage

FILE: hdl/qte_if.sv
// ----------------------------------------------------------------------------
// qte_if: stream interfaces
// Quaternion input channel and angle output channel, valid/ready.
// ----------------------------------------------------------------------------
interface qte_quat_if;
	logic                             valid;
	logic                             ready;
	logic signed [qte_pkg::QW-1:0]    quat_w;
	logic signed [qte_pkg::QW-1:0]    quat_x;
	logic signed [qte_pkg::QW-1:0]    quat_y;
	logic signed [qte_pkg::QW-1:0]    quat_z;

	modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
	modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_angle_if;
	logic                      valid;
	logic                      ready;
	logic [qte_pkg::AW-1:0]    angle_x;
	logic [qte_pkg::AW-1:0]    angle_y;
	logic [qte_pkg::AW-1:0]    angle_z;

	modport source (output valid, angle_x, angle_y, angle_z, input ready);
	modport sink   (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

FILE: hdl/quaternion_to_euler_360_top.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_360_top: quaternion to 0..360 degree (or 0..2pi radian) euler angles
// Fully pipelined: matrix terms, asin via sqrt and CORDIC, atan2 for x and z.
// ----------------------------------------------------------------------------
// Usage:
//   quat carries one quaternion beat (w, x, y, z, signed Q2.14); angle carries
//   the three angles, in degrees * 128 or radians * 8192 per the unit bit
//   written through cfg_we / cfg_wdata (write it only while the pipe is empty).
//   Throughput is one beat per cycle while the receiver does not stall. The
//   pipe runs in order through products, sums and the asin radicand, the
//   bit-per-stage square root, the atan2 pipeline, and unfold, scale and
//   round.
//   Every stage moves on one shared enable; angle is the last stage register.
//   When the receiver stalls a valid result, the whole pipe holds and
//   quat.ready drops in the same cycle; no beat is lost or repeated.
//   Reset clears all valid bits and sets the unit to degrees.
// ----------------------------------------------------------------------------
module quaternion_to_euler_360_top #(
	parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	qte_quat_if.sink           quat,
	qte_angle_if.source        angle,
	input  logic               cfg_we,
	input  logic               cfg_wdata
);

	localparam int L     = qte_pkg::cordic_lat(CORDIC_STAGES);
	localparam int SQ    = qte_pkg::SQ_STEPS;
	localparam int TOTAL = 8 + SQ + L;
	localparam int MW    = qte_pkg::MW;
	localparam int PW    = qte_pkg::PW;
	localparam int RW    = qte_pkg::RW;
	localparam int TW    = qte_pkg::TW;
	localparam int XW    = qte_pkg::XW;
	localparam int PRW   = qte_pkg::TW + qte_pkg::SW;

	qte_pkg::unit_t unit_q;
	logic [TOTAL-1:0] vld_s;
	logic en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q <= qte_pkg::UNIT_DEG;
		end else if (cfg_we) begin
			unit_q <= qte_pkg::unit_t'(cfg_wdata);
		end
	end

	assign en          = !vld_s[TOTAL-1] || angle.ready;
	assign quat.ready  = en;
	assign angle.valid = vld_s[TOTAL-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[TOTAL-2:0], quat.valid};
		end
	end

	// stage 1: products
	logic signed [PW-1:0] ww_s1, xx_s1, yy_s1, zz_s1, xz_s1, wy_s1, xy_s1, wz_s1, yz_s1, wx_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ww_s1 <= quat.quat_w * quat.quat_w;
			xx_s1 <= quat.quat_x * quat.quat_x;
			yy_s1 <= quat.quat_y * quat.quat_y;
			zz_s1 <= quat.quat_z * quat.quat_z;
			xz_s1 <= quat.quat_x * quat.quat_z;
			wy_s1 <= quat.quat_w * quat.quat_y;
			xy_s1 <= quat.quat_x * quat.quat_y;
			wz_s1 <= quat.quat_w * quat.quat_z;
			yz_s1 <= quat.quat_y * quat.quat_z;
			wx_s1 <= quat.quat_w * quat.quat_x;
		end
	end

	// stage 2: matrix terms
	logic signed [MW-1:0] gx_s2, gz_s2, m11_s2, m12_s2, m31_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			gx_s2  <= (MW'(xz_s1) - MW'(wy_s1)) <<< 1;
			m11_s2 <= (MW'(xy_s1) + MW'(wz_s1)) <<< 1;
			m31_s2 <= (MW'(yz_s1) + MW'(wx_s1)) <<< 1;
			gz_s2  <= MW'(ww_s1) - MW'(xx_s1) - MW'(yy_s1) + MW'(zz_s1);
			m12_s2 <= MW'(ww_s1) + MW'(xx_s1) - MW'(yy_s1) - MW'(zz_s1);
		end
	end

	// stage 3: clamp asin argument
	qte_pkg::geo_t geo_s3, geo_s4;
	logic [RW-1:0] gsq_s4;
	logic signed [MW-1:0] gcl;

	always_comb begin
		if (gx_s2 > qte_pkg::ONE_Q28) begin
			gcl = qte_pkg::ONE_Q28;
		end else if (gx_s2 < -qte_pkg::ONE_Q28) begin
			gcl = -qte_pkg::ONE_Q28;
		end else begin
			gcl = gx_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s3.g      <= gcl[qte_pkg::GW-1:0];
			geo_s3.m11    <= m11_s2;
			geo_s3.m12    <= m12_s2;
			geo_s3.m31    <= m31_s2;
			geo_s3.gz     <= gz_s2;
			geo_s3.gx_neg <= gx_s2 < 0;
		end
	end

	// stage 4: g squared
	logic signed [2*qte_pkg::GW-1:0] gsq;
	assign gsq = geo_s3.g * geo_s3.g;

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s4 <= geo_s3;
			gsq_s4 <= gsq[RW-1:0];
		end
	end

	// stage 5 and square root steps: index 0 holds the radicand
	qte_pkg::geo_t geo_p [SQ+1];
	logic [RW-1:0] sv_p  [SQ+1];
	logic [RW:0]   sr_p  [SQ+1];

	always_ff @(posedge clk) begin
		if (en) begin
			geo_p[0] <= geo_s4;
			sv_p[0]  <= qte_pkg::ONE_SQ - gsq_s4;
			sr_p[0]  <= '0;
		end
	end

	for (genvar k = 0; k < SQ; k++) begin : g_sqrt
		localparam logic [RW:0] BIT = (RW+1)'(1) << (RW - 1 - 2*k);
		logic [RW:0] trial;
		assign trial = sr_p[k] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				geo_p[k+1] <= geo_p[k];
				if ({1'b0, sv_p[k]} >= trial) begin
					sv_p[k+1] <= sv_p[k] - trial[RW-1:0];
					sr_p[k+1] <= (sr_p[k] >> 1) + BIT;
				end else begin
					sv_p[k+1] <= sv_p[k];
					sr_p[k+1] <= sr_p[k] >> 1;
				end
			end
		end
	end

	// atan2 units
	logic signed [qte_pkg::ACC_W-1:0] ax_a, ay_a, az_a;
	logic signed [MW-1:0] cs;
	assign cs = $signed(MW'(sr_p[SQ][qte_pkg::GW-1:0]));

	qte_cordic #(.STAGES(CORDIC_STAGES)) u_cx (
		.clk(clk), .en(en), .y_i(geo_p[SQ].m11), .x_i(geo_p[SQ].m12), .ang(ax_a)
	);
	qte_cordic #(.STAGES(CORDIC_STAGES)) u_cy (
		.clk(clk), .en(en), .y_i(MW'(geo_p[SQ].g)), .x_i(cs), .ang(ay_a)
	);
	qte_cordic #(.STAGES(CORDIC_STAGES)) u_cz (
		.clk(clk), .en(en), .y_i(geo_p[SQ].m31), .x_i(geo_p[SQ].gz), .ang(az_a)
	);

	// quadrant flags {gz < 0, gx < 0}
	logic [1:0] flg_p [L+1];
	assign flg_p[0] = {geo_p[SQ].gz < 0, geo_p[SQ].gx_neg};

	for (genvar k = 0; k < L; k++) begin : g_flag
		always_ff @(posedge clk) begin
			if (en) begin
				flg_p[k+1] <= flg_p[k];
			end
		end
	end

	// unfold and clamp
	logic signed [XW-1:0] axe, aye, aze, axu, ayu, azu;
	logic [TW-1:0] tx_s, ty_s, tz_s;

	assign axe = XW'(ax_a);
	assign aye = XW'(ay_a);
	assign aze = XW'(az_a);

	always_comb begin
		axu = (axe > 0) ? axe : qte_pkg::FULL_TURN_X + axe;
		azu = (aze > 0) ? qte_pkg::FULL_TURN_X - aze : -aze;
		if (flg_p[L][1]) begin
			ayu = qte_pkg::HALF_TURN_X - aye;
		end else if (flg_p[L][0]) begin
			ayu = qte_pkg::FULL_TURN_X + aye;
		end else begin
			ayu = aye;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tx_s <= qte_pkg::to_turn(axu);
			ty_s <= qte_pkg::to_turn(ayu);
			tz_s <= qte_pkg::to_turn(azu);
		end
	end

	// scale
	logic [PRW-1:0] px_s, py_s, pz_s;
	logic [qte_pkg::SW-1:0] scale;
	assign scale = (unit_q == qte_pkg::UNIT_RAD) ? qte_pkg::RAD_SCALE : qte_pkg::DEG_SCALE;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s <= tx_s * scale;
			py_s <= ty_s * scale;
			pz_s <= tz_s * scale;
		end
	end

	// round into output register
	always_ff @(posedge clk) begin
		if (en) begin
			angle.angle_x <= qte_pkg::round_unit(px_s, unit_q);
			angle.angle_y <= qte_pkg::round_unit(py_s, unit_q);
			angle.angle_z <= qte_pkg::round_unit(pz_s, unit_q);
		end
	end

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid && quat.ready |=> vld_s[0])
		else $error("accepted beat did not enter stage 1");

	a_sqrt: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[4+SQ] |-> sr_p[SQ] <= (RW+1)'(qte_pkg::ONE_Q28))
		else $error("sqrt result above one");

	a_deg: assert property (@(posedge clk) disable iff (!arst_n)
		angle.valid && unit_q == qte_pkg::UNIT_DEG |->
		angle.angle_x <= qte_pkg::DEG_MAX && angle.angle_y <= qte_pkg::DEG_MAX &&
		angle.angle_z <= qte_pkg::DEG_MAX)
		else $error("degree angle out of range");

	a_rad: assert property (@(posedge clk) disable iff (!arst_n)
		angle.valid && unit_q == qte_pkg::UNIT_RAD |->
		angle.angle_x <= qte_pkg::RAD_MAX && angle.angle_y <= qte_pkg::RAD_MAX &&
		angle.angle_z <= qte_pkg::RAD_MAX)
		else $error("radian angle out of range");

endmodule

FILE: hdl/qte_cordic.sv
// ----------------------------------------------------------------------------
// qte_cordic: pipelined atan2
// Special-case detect and half-plane fold, normalizing shift stages, then
// one vectoring CORDIC iteration per stage; stages past MAX_STAGES pass through.
// ----------------------------------------------------------------------------
module qte_cordic #(
	parameter int STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [qte_pkg::MW-1:0]     y_i,
	input  logic signed [qte_pkg::MW-1:0]     x_i,
	output logic signed [qte_pkg::ACC_W-1:0]  ang
);

	localparam int L  = qte_pkg::cordic_lat(STAGES);
	localparam int NI = qte_pkg::NORM_STEPS + 2;  // index of first iteration output
	localparam int CW = qte_pkg::CW;
	localparam int AC = qte_pkg::ACC_W;

	logic signed [CW-1:0] x_s    [L];
	logic signed [CW-1:0] y_s    [L];
	logic signed [AC-1:0] acc_s  [L];
	logic                 spec_s [L];
	logic signed [AC-1:0] sval_s [L];

	logic signed [CW-1:0] xe, ye;

	assign xe = CW'(x_i);
	assign ye = CW'(y_i);

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s[0] <= (y_i == '0) || (x_i == '0);
			if (y_i == '0) begin
				sval_s[0] <= (x_i < 0) ? qte_pkg::HALF_TURN : '0;
			end else begin
				sval_s[0] <= (y_i > 0) ? qte_pkg::QUARTER_TURN : -qte_pkg::QUARTER_TURN;
			end
			if (x_i < 0) begin
				x_s[0]   <= -xe;
				y_s[0]   <= -ye;
				acc_s[0] <= (y_i > 0) ? qte_pkg::HALF_TURN : -qte_pkg::HALF_TURN;
			end else begin
				x_s[0]   <= xe;
				y_s[0]   <= ye;
				acc_s[0] <= '0;
			end
		end
	end

	for (genvar k = 1; k < L; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (en) begin
				spec_s[k] <= spec_s[k-1];
				sval_s[k] <= sval_s[k-1];
			end
		end
	end

	// greedy normalization: largest shift that keeps all terms below 2^30,
	// then the final doubling
	for (genvar j = 0; j <= qte_pkg::NORM_STEPS; j++) begin : g_norm
		localparam int SH = (j < qte_pkg::NORM_STEPS) ? (16 >> j) : 0;
		localparam int DS = (j < qte_pkg::NORM_STEPS) ? (16 >> j) : 1;
		logic signed [CW-1:0] lim;
		logic                 fit;
		assign lim = CW'(64'sd1 <<< (30 - SH));
		assign fit = (x_s[j] < lim) && (y_s[j] < lim) && (y_s[j] > -lim);
		always_ff @(posedge clk) begin
			if (en) begin
				acc_s[j+1] <= acc_s[j];
				if (fit) begin
					x_s[j+1] <= x_s[j] <<< DS;
					y_s[j+1] <= y_s[j] <<< DS;
				end else begin
					x_s[j+1] <= x_s[j];
					y_s[j+1] <= y_s[j];
				end
			end
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_iter
		localparam int SI = (i < qte_pkg::MAX_STAGES) ? i : qte_pkg::MAX_STAGES - 1;
		logic signed [CW-1:0] dx, dy;
		logic signed [AC-1:0] at;
		assign dx = x_s[NI+i-1] >>> SI;
		assign dy = y_s[NI+i-1] >>> SI;
		assign at = (i < qte_pkg::MAX_STAGES) ? AC'(qte_pkg::atan_at(SI)) : '0;
		always_ff @(posedge clk) begin
			if (en) begin
				if (i >= qte_pkg::MAX_STAGES) begin
					x_s[NI+i]   <= x_s[NI+i-1];
					y_s[NI+i]   <= y_s[NI+i-1];
					acc_s[NI+i] <= acc_s[NI+i-1];
				end else if (y_s[NI+i-1] > 0) begin
					x_s[NI+i]   <= x_s[NI+i-1] + dy;
					y_s[NI+i]   <= y_s[NI+i-1] - dx;
					acc_s[NI+i] <= acc_s[NI+i-1] + at;
				end else begin
					x_s[NI+i]   <= x_s[NI+i-1] - dy;
					y_s[NI+i]   <= y_s[NI+i-1] + dx;
					acc_s[NI+i] <= acc_s[NI+i-1] - at;
				end
			end
		end
	end

	assign ang = spec_s[L-1] ? sval_s[L-1] : acc_s[L-1];

endmodule
